>>> rtl/dss_pkg.sv
// Shared widths, register indexes and pipeline word types for the
// five-point diffusion sweep. No dependencies.
package dss_pkg;

  localparam int MAX_DIM = 1024;
  localparam int ADDR_W  = $clog2(MAX_DIM);
  localparam int DIM_W   = 11;
  localparam int CELL_W  = 32;
  localparam int GAIN_W  = 24;
  localparam int SUM_W   = 56;
  localparam int MAG_W   = CELL_W + 2;
  localparam int PROD_W  = MAG_W + GAIN_W;
  localparam int Q_W     = PROD_W - GAIN_W + 1;

  localparam int IN_TDATA_W  = CELL_W;
  localparam int OUT_USED_W  = 2 * ADDR_W + CELL_W + SUM_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd16777;
  localparam logic [DIM_W-1:0]  DIM_RESET  = 11'd1000;
  localparam logic [DIM_W-1:0]  DIM_MIN    = 11'd3;
  localparam logic [DIM_W-1:0]  DIM_MAX    = DIM_W'(MAX_DIM);

  // Neighbourhood of the cell being updated
  typedef struct packed {
    logic [CELL_W-1:0] up;
    logic [CELL_W-1:0] down;
    logic [CELL_W-1:0] left;
    logic [CELL_W-1:0] right;
    logic [CELL_W-1:0] center;
  } tap_t;

  // Per-input control travelling alongside the arithmetic
  typedef struct packed {
    logic [ADDR_W-1:0] row_a;
    logic [ADDR_W-1:0] col;
    logic [CELL_W-1:0] pass;
    logic [CELL_W-1:0] incoming;
    logic              interior;
    logic              two;
    logic              done;
    logic              clr;
  } item_t;

  // One result word
  typedef struct packed {
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] col;
    logic [CELL_W-1:0] value;
    logic [SUM_W-1:0]  sum;
    logic              done;
    logic              last;
  } res_t;

endpackage

>>> rtl/diffusion_stencil_sweep_unit.sv
// An accepted word reaches out_ through the p1, s2 to s5 and emit hold registers.
// Throughput: one input word per cycle unless out_tready stalls; last-row inputs hold
// input while their second result word goes through the single output register.
// The line buffers are two 1024 x 32 RAMs, one write and one read port each.
// Reset (rst_n low, synchronous): position, change sum and all valid flags clear,
// registers take gain 16777 and a 1000 x 1000 grid; line buffers are not cleared.
module diffusion_stencil_sweep_unit
  import dss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] cell_value
  input  logic                   in_tuser,   // [0] sweep_start
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_row, out_col, new_value,
                                             // abs_change_sum, zero fill
  output logic                   out_tlast,  // run_last
  output logic                   out_tuser,  // [0] sweep_done
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [GAIN_W-1:0]      cfg_data
);

  logic [GAIN_W-1:0] gain_r;
  logic [DIM_W-1:0]  grid_w_r, grid_h_r, dim_clamp;
  logic              en, accept;
  logic              p1_valid, s5_valid, s5_minus;
  tap_t              p1_tap;
  item_t             p1_item, s5_item;
  logic [Q_W-1:0]    s5_q;
  logic [CELL_W-1:0] s5_center;
  res_t              res;

  // Clamp a dimension write into the supported range
  always_comb begin
    dim_clamp = cfg_data[DIM_W-1:0];
    if (dim_clamp < DIM_MIN) begin
      dim_clamp = DIM_MIN;
    end else if (dim_clamp > DIM_MAX) begin
      dim_clamp = DIM_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RESET;
      grid_w_r <= DIM_RESET;
      grid_h_r <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN:   gain_r   <= cfg_data;
        REG_WIDTH:  grid_w_r <= dim_clamp;
        REG_HEIGHT: grid_h_r <= dim_clamp;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // The whole pipeline advances together; hold input while the tail is full
  assign in_tready = en && rst_n;
  assign accept    = in_tvalid && in_tready;

  dss_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .accept      (accept),
    .cell_value  (in_tdata[CELL_W-1:0]),
    .sweep_start (in_tuser),
    .grid_w      (grid_w_r),
    .grid_h      (grid_h_r),
    .p1_valid    (p1_valid),
    .p1_tap      (p1_tap),
    .p1_item     (p1_item)
  );

  dss_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .p1_valid  (p1_valid),
    .p1_tap    (p1_tap),
    .p1_item   (p1_item),
    .gain      (gain_r),
    .s5_valid  (s5_valid),
    .s5_q      (s5_q),
    .s5_minus  (s5_minus),
    .s5_center (s5_center),
    .s5_item   (s5_item)
  );

  dss_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .s5_valid  (s5_valid),
    .s5_q      (s5_q),
    .s5_minus  (s5_minus),
    .s5_center (s5_center),
    .s5_item   (s5_item),
    .out_ready (out_tready),
    .en        (en),
    .out_valid (out_tvalid),
    .out_res   (res)
  );

  // Pack the result word, first field lowest
  assign out_tdata = {{(OUT_TDATA_W-OUT_USED_W){1'b0}},
                      res.sum, res.value, res.col, res.row};
  assign out_tlast = res.last;
  assign out_tuser = res.done;

endmodule

>>> rtl/dss_ram.sv
// Generic single-write, single-read synchronous RAM, read-first, registered
// read data. No dependencies.
module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/dss_window.sv
// Raster position tracking and the two line buffers; delivers the stencil
// neighbourhood, registered, in the cycle after acceptance. Depends on dss_pkg, dss_ram.
module dss_window
  import dss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              accept,
  input  logic [CELL_W-1:0] cell_value,
  input  logic              sweep_start,
  input  logic [DIM_W-1:0]  grid_w,
  input  logic [DIM_W-1:0]  grid_h,
  output logic              p1_valid,
  output tap_t              p1_tap,
  output item_t             p1_item
);

  logic [ADDR_W-1:0] row_r, col_r, row_nxt, col_nxt;
  logic [ADDR_W-1:0] r, c, mid_raddr;
  logic [DIM_W-1:0]  wm1, hm1, col_inc, row_inc;
  logic              restart, last_col, last_row, top_row;
  logic [CELL_W-1:0] center, up_rdata, mid_rdata;
  logic [CELL_W-1:0] last_center_r;
  logic              p1_valid_r;
  logic [CELL_W-1:0] p1_center_r, p1_down_r, p1_left_r;
  item_t             p1_item_r, item_nxt;

  always_comb begin
    restart  = sweep_start || ({1'b0, row_r} >= grid_h) || ({1'b0, col_r} >= grid_w);
    r        = restart ? '0 : row_r;
    c        = restart ? '0 : col_r;
    wm1      = grid_w - DIM_W'(1);
    hm1      = grid_h - DIM_W'(1);
    last_col = ({1'b0, c} == wm1);
    last_row = ({1'b0, r} == hm1);
    top_row  = (r == '0);
    // prefetch the right neighbour; on the last column fetch column 0 for
    // the next row's first centre
    mid_raddr = last_col ? '0 : c + ADDR_W'(1);
    center    = mid_rdata;

    col_inc = {1'b0, c} + DIM_W'(1);
    row_inc = {1'b0, r} + DIM_W'(1);
    col_nxt = col_inc[ADDR_W-1:0];
    row_nxt = r;
    if (col_inc >= grid_w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= grid_h) ? '0 : row_inc[ADDR_W-1:0];
    end

    item_nxt.row_a    = top_row ? '0 : r - ADDR_W'(1);
    item_nxt.col      = c;
    item_nxt.pass     = top_row ? cell_value : center;
    item_nxt.incoming = cell_value;
    item_nxt.interior = (r >= ADDR_W'(2)) && (c != '0) && !last_col;
    item_nxt.two      = last_row;
    item_nxt.done     = last_row && last_col;
    item_nxt.clr      = top_row && (c == '0);
  end

  dss_ram #(.WIDTH(CELL_W), .DEPTH(MAX_DIM)) u_upper (
    .clk   (clk),
    .we    (accept),
    .waddr (c),
    .wdata (center),
    .re    (accept),
    .raddr (c),
    .rdata (up_rdata)
  );

  dss_ram #(.WIDTH(CELL_W), .DEPTH(MAX_DIM)) u_middle (
    .clk   (clk),
    .we    (accept),
    .waddr (c),
    .wdata (cell_value),
    .re    (accept),
    .raddr (mid_raddr),
    .rdata (mid_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      p1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (en) begin
        p1_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_center_r <= center;
      p1_center_r   <= center;
      p1_down_r     <= cell_value;
      p1_left_r     <= last_center_r;
      p1_item_r     <= item_nxt;
    end
  end

  assign p1_valid      = p1_valid_r;
  assign p1_item       = p1_item_r;
  assign p1_tap.up     = up_rdata;
  assign p1_tap.down   = p1_down_r;
  assign p1_tap.left   = p1_left_r;
  assign p1_tap.right  = mid_rdata;
  assign p1_tap.center = p1_center_r;

endmodule

>>> rtl/dss_update.sv
// Arithmetic pipeline: Laplacian, magnitude, gain product and rounding.
// Depends on dss_pkg.
module dss_update
  import dss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              p1_valid,
  input  tap_t              p1_tap,
  input  item_t             p1_item,
  input  logic [GAIN_W-1:0] gain,
  output logic              s5_valid,
  output logic [Q_W-1:0]    s5_q,
  output logic              s5_minus,
  output logic [CELL_W-1:0] s5_center,
  output item_t             s5_item
);

  logic              s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;
  logic [MAG_W-1:0]  s2_pos_r, s2_neg_r, s3_mag_r;
  logic [PROD_W-1:0] s4_prod_r;
  logic [Q_W-1:0]    s5_q_r;
  logic              s3_minus_r, s4_minus_r, s5_minus_r;
  logic [CELL_W-1:0] s2_center_r, s3_center_r, s4_center_r, s5_center_r;
  item_t             s2_item_r, s3_item_r, s4_item_r, s5_item_r;
  logic              minus;

  assign minus = s2_neg_r > s2_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= p1_valid;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // sum of the four neighbours against four times the centre
      s2_pos_r    <= MAG_W'(p1_tap.up) + MAG_W'(p1_tap.down)
                   + MAG_W'(p1_tap.left) + MAG_W'(p1_tap.right);
      s2_neg_r    <= {p1_tap.center, 2'b00};
      s2_center_r <= p1_tap.center;
      s2_item_r   <= p1_item;

      s3_minus_r  <= minus;
      s3_mag_r    <= minus ? s2_neg_r - s2_pos_r : s2_pos_r - s2_neg_r;
      s3_center_r <= s2_center_r;
      s3_item_r   <= s2_item_r;

      s4_prod_r   <= PROD_W'(s3_mag_r) * PROD_W'(gain);
      s4_minus_r  <= s3_minus_r;
      s4_center_r <= s3_center_r;
      s4_item_r   <= s3_item_r;

      // round to nearest at the gain's fraction point, ties away from zero
      s5_q_r      <= Q_W'(s4_prod_r[PROD_W-1:GAIN_W]) + Q_W'(s4_prod_r[GAIN_W-1]);
      s5_minus_r  <= s4_minus_r;
      s5_center_r <= s4_center_r;
      s5_item_r   <= s4_item_r;
    end
  end

  assign s5_valid  = s5_valid_r;
  assign s5_q      = s5_q_r;
  assign s5_minus  = s5_minus_r;
  assign s5_center = s5_center_r;
  assign s5_item   = s5_item_r;

endmodule

>>> rtl/dss_emit.sv
// Saturating cell update, change accumulator and output register; splits
// a last-row input into its two result words. Depends on dss_pkg.
module dss_emit
  import dss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s5_valid,
  input  logic [Q_W-1:0]    s5_q,
  input  logic              s5_minus,
  input  logic [CELL_W-1:0] s5_center,
  input  item_t             s5_item,
  input  logic              out_ready,
  output logic              en,
  output logic              out_valid,
  output res_t              out_res
);

  logic              h_valid_r, h_phase_r, out_valid_r;
  item_t             h_item_r;
  logic [CELL_W-1:0] h_nv_r, h_chg_r, nv, chg;
  logic [Q_W:0]      plus_wide;
  logic [SUM_W-1:0]  acc_r, acc_nxt, acc_base;
  logic [SUM_W:0]    acc_wide;
  logic              load_out, release_item;
  res_t              res_r, res_nxt;

  always_comb begin
    plus_wide = {1'b0, s5_q} + (Q_W+1)'(s5_center);
    nv        = s5_item.pass;
    chg       = '0;
    if (s5_item.interior) begin
      if (s5_minus) begin
        nv  = (s5_q >= Q_W'(s5_center)) ? '0 : s5_center - s5_q[CELL_W-1:0];
        chg = s5_center - nv;
      end else begin
        nv  = (plus_wide > (Q_W+1)'({CELL_W{1'b1}})) ? '1 : plus_wide[CELL_W-1:0];
        chg = nv - s5_center;
      end
    end
  end

  always_comb begin
    load_out     = h_valid_r && (!out_valid_r || out_ready);
    release_item = load_out && (h_phase_r || !h_item_r.two);
    en           = !h_valid_r || release_item;

    acc_base = h_item_r.clr ? '0 : acc_r;
    acc_wide = {1'b0, acc_base} + (SUM_W+1)'(h_chg_r);
    acc_nxt  = acc_wide[SUM_W] ? '1 : acc_wide[SUM_W-1:0];

    if (!h_phase_r) begin
      res_nxt.row   = h_item_r.row_a;
      res_nxt.col   = h_item_r.col;
      res_nxt.value = h_nv_r;
      res_nxt.sum   = '0;
      res_nxt.done  = 1'b0;
      res_nxt.last  = !h_item_r.two;
    end else begin
      res_nxt.row   = h_item_r.row_a + ADDR_W'(1);
      res_nxt.col   = h_item_r.col;
      res_nxt.value = h_item_r.incoming;
      res_nxt.sum   = h_item_r.done ? acc_r : '0;
      res_nxt.done  = h_item_r.done;
      res_nxt.last  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_valid_r   <= 1'b0;
      h_phase_r   <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      if (en) begin
        h_valid_r <= s5_valid;
        h_phase_r <= 1'b0;
      end else if (load_out) begin
        h_phase_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // count the change once, with the first word of the input
      if (load_out && !h_phase_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_item_r <= s5_item;
      h_nv_r   <= nv;
      h_chg_r  <= chg;
    end
    if (load_out) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

>>> rtl/dss_checker.sv
// Port-level checks on the result stream of the diffusion sweep unit, bound
// to the top level. Depends on dss_pkg.
module dss_checker
  import dss_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic                   out_tuser
);

  // a stalled word stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // end of sweep closes the run of its input
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("sweep end without run end");

  // the change sum is shown only on the sweep's final word
  a_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[OUT_USED_W-1:OUT_USED_W-SUM_W] == '0)
    else $error("change sum outside sweep end");

  // the final word sits in the last column, never in the first two
  a_done_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[2*ADDR_W-1:ADDR_W] >= ADDR_W'(2))
    else $error("sweep end on a boundary column");

endmodule

bind diffusion_stencil_sweep_unit dss_checker u_dss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
